FILE: design/two_kernel_gradient_energy_map_core_defines.svh
// Assertion macros shared by the gradient energy map RTL.
// Included by modules that check their own control logic; no dependencies.
`ifndef TWO_KERNEL_GRADIENT_ENERGY_MAP_CORE_DEFINES_SVH
`define TWO_KERNEL_GRADIENT_ENERGY_MAP_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TKGE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TKGE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tkge_pkg.sv
// Shared types, constants and helpers of the gradient energy map.
// No dependencies; imported by every module of the block.
package tkge_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int SIZE_W   = 9;
    localparam int KERN_W   = 45;
    localparam int COEF_W   = 5;
    localparam int PIX_W    = 8;
    localparam int ENERGY_W = 16;
    localparam int DATA_W   = 64;
    localparam int PADDR_W  = 5;

    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_KERNEL_A = 2'd2;
    localparam logic [1:0] REG_KERNEL_B = 2'd3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NOT_READY = 1'b1;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_FETCH = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [PIX_W-1:0]   pixel;
    } cmd_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
        logic [KERN_W-1:0]  kernel_a;
        logic [KERN_W-1:0]  kernel_b;
        logic               restart;
    } cfg_t;

    // Pick coefficient idx (k*3+l) out of a packed kernel.
    function automatic logic signed [COEF_W-1:0] coef_at(logic [KERN_W-1:0] kern,
                                                         logic [3:0] idx);
        logic signed [COEF_W-1:0] c;
        c = kern[COEF_W*idx +: COEF_W];
        return c;
    endfunction

endpackage

FILE: design/two_kernel_gradient_energy_map_core.sv
// Top level of the two-kernel gradient energy map; depends on tkge_pkg, tkge_front and
// tkge_back. Load items (op 0) write the next raster pixel in the back end; the load that
// completes the image starts an energy pass that steps through each pixel with nine window
// taps through the single pixel memory read port, a drain and a write. Fetch items (op 1)
// do an energy memory read, then an 8-step restoring divider for (e-min)*255/range. A
// fetch before the image is complete returns status 1 without a divide. A two-entry queue
// sits between the command port and the back end; busy is high only while that queue is
// full. Results appear for one cycle with done high and cannot be stalled, so the receiver
// must take them when shown.
module two_kernel_gradient_energy_map_core
    import tkge_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                op,
    input  logic [PIX_W-1:0]    pixel,
    output logic                done,
    output logic [PIX_W-1:0]    value,
    output logic                last,
    output logic                status,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    logic [SIZE_W-1:0]  width_reg, width_next;
    logic [SIZE_W-1:0]  height_reg, height_next;
    logic [KERN_W-1:0]  kernel_a_reg, kernel_a_next;
    logic [KERN_W-1:0]  kernel_b_reg, kernel_b_next;
    logic               wr_en;
    logic [1:0]         reg_idx;
    cfg_t               cfg;
    logic               cmd_valid;
    cmd_t               cmd;
    logic               cmd_pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes; any size write restarts the image.
    always_comb
    begin
        width_next    = width_reg;
        height_next   = height_reg;
        kernel_a_next = kernel_a_reg;
        kernel_b_next = kernel_b_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_WIDTH:    width_next    = pwdata[SIZE_W-1:0];
                REG_HEIGHT:   height_next   = pwdata[SIZE_W-1:0];
                REG_KERNEL_A: kernel_a_next = pwdata[KERN_W-1:0];
                REG_KERNEL_B: kernel_b_next = pwdata[KERN_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_WIDTH:    prdata = DATA_W'(width_reg);
            REG_HEIGHT:   prdata = DATA_W'(height_reg);
            REG_KERNEL_A: prdata = DATA_W'(kernel_a_reg);
            REG_KERNEL_B: prdata = DATA_W'(kernel_b_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= SIZE_RESET;
            height_reg   <= SIZE_RESET;
            kernel_a_reg <= '0;
            kernel_b_reg <= '0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            kernel_a_reg <= kernel_a_next;
            kernel_b_reg <= kernel_b_next;
        end
    end

    always_comb
    begin
        cfg.width    = width_reg;
        cfg.height   = height_reg;
        cfg.kernel_a = kernel_a_reg;
        cfg.kernel_b = kernel_b_reg;
        cfg.restart  = wr_en && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT);
    end

    // Accept and queue items.
    tkge_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (op),
        .pixel     (pixel),
        .busy      (busy),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Execute loads, the energy pass and fetches.
    tkge_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .done      (done),
        .value     (value),
        .last      (last),
        .status    (status)
    );

endmodule

FILE: design/tkge_front.sv
// Front end: accepts command items, decodes them and queues them.
// Depends on tkge_pkg.
module tkge_front
    import tkge_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              op,
    input  logic [PIX_W-1:0]  pixel,
    output logic              busy,
    output logic              cmd_valid,
    output cmd_t              cmd,
    input  logic              cmd_pop
);

    cmd_t        q_mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    cmd_t        in_cmd;

    assign busy      = (count_reg == 2'd2);
    assign push      = start && !busy;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        in_cmd.kind  = op ? CMD_FETCH : CMD_LOAD;
        in_cmd.pixel = pixel;
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/tkge_div.sv
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
// Depends on tkge_pkg; expects num < 256 * den.
module tkge_div
    import tkge_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [ENERGY_W+7:0]   num,
    input  logic [ENERGY_W-1:0]   den,
    output logic                  done,
    output logic [PIX_W-1:0]      quo
);

    logic [ENERGY_W-1:0]  rem_reg, rem_next;
    logic [PIX_W-1:0]     low_reg, low_next;
    logic [ENERGY_W-1:0]  den_reg;
    logic [3:0]           cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [ENERGY_W:0]    trial;
    logic                 ge;

    assign trial = {rem_reg, low_reg[PIX_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign done  = done_reg;
    assign quo   = low_reg;

    always_comb
    begin
        rem_next  = ge ? ENERGY_W'(trial - {1'b0, den_reg}) : trial[ENERGY_W-1:0];
        low_next  = {low_reg[PIX_W-2:0], ge};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = 4'd8;
        end
        else if (cnt_reg != 4'd0)
        begin
            cnt_next  = cnt_reg - 4'd1;
            done_next = (cnt_reg == 4'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[ENERGY_W+7:8];
            low_reg <= num[7:0];
            den_reg <= den;
        end
        else if (cnt_reg != 4'd0)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 4'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

endmodule

FILE: design/tkge_back.sv
// Back end: pixel and energy memories, energy sweep, fetch normalization.
// Depends on tkge_pkg, tkge_div and the assertion macro header.
`include "two_kernel_gradient_energy_map_core_defines.svh"
module tkge_back
    import tkge_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 cmd_valid,
    input  cmd_t                 cmd,
    output logic                 cmd_pop,
    output logic                 done,
    output logic [PIX_W-1:0]     value,
    output logic                 last,
    output logic                 status
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int ACC_W = 18;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_TAP   = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_WRITE = 6'b001000,
        ST_FREAD = 6'b010000,
        ST_FDIV  = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              load_count_reg, load_count_next;
    logic [CW-1:0]              fetch_count_reg, fetch_count_next;
    logic [ENERGY_W-1:0]        energy_min_reg, energy_min_next;
    logic [ENERGY_W-1:0]        energy_max_reg, energy_max_next;
    logic                       image_ready_reg, image_ready_next;
    logic [CW-1:0]              total_reg;
    logic [XW-1:0]              x_reg, x_next;
    logic [YW-1:0]              y_reg, y_next;
    logic [AW-1:0]              base_reg, base_next;
    logic [1:0]                 k_reg, k_next;
    logic [1:0]                 l_reg, l_next;
    logic                       mac_valid_reg;
    logic [3:0]                 mac_idx_reg;
    logic signed [ACC_W-1:0]    acc_a_reg, acc_a_next;
    logic signed [ACC_W-1:0]    acc_b_reg, acc_b_next;
    logic                       last_pend_reg, last_pend_next;
    logic                       done_reg, done_next;
    logic [PIX_W-1:0]           value_reg, value_next;
    logic                       last_reg, last_next;
    logic                       status_reg, status_next;

    logic [PIX_W-1:0]           pix_mem [DEPTH];
    logic [ENERGY_W-1:0]        en_mem [DEPTH];
    logic [PIX_W-1:0]           pix_rd_reg;
    logic [ENERGY_W-1:0]        en_rd_reg;

    logic [WW-1:0]              w_eff;
    logic [HW-1:0]              h_eff;
    logic [XW-1:0]              wm1;
    logic [YW-1:0]              hm1;
    logic [AW-1:0]              w_a;
    logic [CW-1:0]              load_idx, load_inc;
    logic                       pix_we, en_re, en_we;
    logic [XW-1:0]              col;
    logic [AW-1:0]              row_base, tap_addr, en_waddr;
    logic signed [COEF_W-1:0]   coef_a, coef_b;
    logic signed [13:0]         prod_a, prod_b;
    logic [ACC_W-1:0]           mag_a, mag_b;
    logic [ACC_W:0]             mag_sum;
    logic [ENERGY_W-1:0]        energy;
    logic [ENERGY_W-1:0]        diff, range_raw, den;
    logic [ENERGY_W+7:0]        num;
    logic                       div_start, div_done;
    logic [PIX_W-1:0]           div_quo;

    // Effective image size: zero counts as one, large values saturate.
    always_comb
    begin
        if (cfg.width == '0)
            w_eff = WW'(1);
        else if (32'(cfg.width) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(cfg.width);
        if (cfg.height == '0)
            h_eff = HW'(1);
        else if (32'(cfg.height) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(cfg.height);
    end

    assign wm1 = XW'(w_eff - WW'(1));
    assign hm1 = YW'(h_eff - HW'(1));
    assign w_a = AW'(w_eff);

    assign load_idx = image_ready_reg ? '0 : load_count_reg;
    assign load_inc = load_idx + CW'(1);
    assign cmd_pop  = cmd_valid && (state_reg == ST_IDLE);

    // Window tap address with replicated borders.
    always_comb
    begin
        unique case (k_reg)
            2'd0:    col = (x_reg == '0) ? x_reg : x_reg - XW'(1);
            2'd1:    col = x_reg;
            default: col = (x_reg == wm1) ? x_reg : x_reg + XW'(1);
        endcase
        unique case (l_reg)
            2'd0:    row_base = (y_reg == '0) ? base_reg : base_reg - w_a;
            2'd1:    row_base = base_reg;
            default: row_base = (y_reg == hm1) ? base_reg : base_reg + w_a;
        endcase
        tap_addr = row_base + AW'(col);
        en_waddr = base_reg + AW'(x_reg);
    end

    assign coef_a = coef_at(cfg.kernel_a, mac_idx_reg);
    assign coef_b = coef_at(cfg.kernel_b, mac_idx_reg);
    assign prod_a = $signed({1'b0, pix_rd_reg}) * coef_a;
    assign prod_b = $signed({1'b0, pix_rd_reg}) * coef_b;

    assign mag_a   = acc_a_reg[ACC_W-1] ? ACC_W'(-acc_a_reg) : ACC_W'(acc_a_reg);
    assign mag_b   = acc_b_reg[ACC_W-1] ? ACC_W'(-acc_b_reg) : ACC_W'(acc_b_reg);
    assign mag_sum = {1'b0, mag_a} + {1'b0, mag_b};
    assign energy  = (mag_sum[ACC_W:ENERGY_W+1] != '0) ? '1 : mag_sum[ENERGY_W:1];

    assign diff      = en_rd_reg - energy_min_reg;
    assign num       = {diff, 8'h00} - {8'h00, diff};
    assign range_raw = energy_max_reg - energy_min_reg;
    assign den       = (range_raw == '0) ? ENERGY_W'(1) : range_raw;

    always_comb
    begin
        state_next       = state_reg;
        load_count_next  = load_count_reg;
        fetch_count_next = fetch_count_reg;
        energy_min_next  = energy_min_reg;
        energy_max_next  = energy_max_reg;
        image_ready_next = image_ready_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        base_next        = base_reg;
        k_next           = k_reg;
        l_next           = l_reg;
        acc_a_next       = mac_valid_reg ? acc_a_reg + ACC_W'(prod_a) : acc_a_reg;
        acc_b_next       = mac_valid_reg ? acc_b_reg + ACC_W'(prod_b) : acc_b_reg;
        last_pend_next   = last_pend_reg;
        done_next        = 1'b0;
        value_next       = value_reg;
        last_next        = last_reg;
        status_next      = status_reg;
        pix_we           = 1'b0;
        en_re            = 1'b0;
        en_we            = 1'b0;
        div_start        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd.kind == CMD_LOAD)
                begin
                    // Load after completion starts a new image.
                    if (image_ready_reg)
                    begin
                        fetch_count_next = '0;
                        energy_min_next  = '1;
                        energy_max_next  = '0;
                        image_ready_next = 1'b0;
                    end
                    pix_we          = 1'b1;
                    load_count_next = load_inc;
                    if (load_inc >= total_reg)
                    begin
                        x_next     = '0;
                        y_next     = '0;
                        base_next  = '0;
                        k_next     = 2'd0;
                        l_next     = 2'd0;
                        acc_a_next = '0;
                        acc_b_next = '0;
                        state_next = ST_TAP;
                    end
                end
                else if (cmd_valid)
                begin
                    if (!image_ready_reg)
                    begin
                        done_next   = 1'b1;
                        value_next  = '0;
                        last_next   = 1'b0;
                        status_next = STATUS_NOT_READY;
                    end
                    else
                    begin
                        en_re            = 1'b1;
                        last_pend_next   = (fetch_count_reg == total_reg - CW'(1));
                        fetch_count_next = (fetch_count_reg + CW'(1) >= total_reg) ?
                                           '0 : fetch_count_reg + CW'(1);
                        state_next       = ST_FREAD;
                    end
                end
            end
            ST_TAP:
            begin
                // Advance the row offset first, then the column offset.
                if (l_reg == 2'd2)
                begin
                    l_next = 2'd0;
                    if (k_reg == 2'd2)
                    begin
                        k_next     = 2'd0;
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
                else
                begin
                    l_next = l_reg + 2'd1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                en_we      = 1'b1;
                acc_a_next = '0;
                acc_b_next = '0;
                if (energy < energy_min_reg)
                    energy_min_next = energy;
                if (energy > energy_max_reg)
                    energy_max_next = energy;
                state_next = ST_TAP;
                if (x_reg == wm1)
                begin
                    x_next = '0;
                    if (y_reg == hm1)
                    begin
                        image_ready_next = 1'b1;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        y_next    = y_reg + YW'(1);
                        base_next = base_reg + w_a;
                    end
                end
                else
                begin
                    x_next = x_reg + XW'(1);
                end
            end
            ST_FREAD:
            begin
                div_start  = 1'b1;
                state_next = ST_FDIV;
            end
            ST_FDIV:
            begin
                if (div_done)
                begin
                    done_next   = 1'b1;
                    value_next  = div_quo;
                    last_next   = last_pend_reg;
                    status_next = STATUS_OK;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Size write restarts the image; the user must write sizes only while idle, not enforced here.
        if (cfg.restart)
        begin
            load_count_next  = '0;
            fetch_count_next = '0;
            energy_min_next  = '1;
            energy_max_next  = '0;
            image_ready_next = 1'b0;
        end
    end

    tkge_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (pix_we)
            pix_mem[load_idx[AW-1:0]] <= cmd.pixel;
        if (state_reg == ST_TAP)
            pix_rd_reg <= pix_mem[tap_addr];
    end

    always_ff @(posedge clk)
    begin
        if (en_we)
            en_mem[en_waddr] <= energy;
        if (en_re)
            en_rd_reg <= en_mem[fetch_count_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        total_reg     <= CW'(w_eff) * CW'(h_eff);
        x_reg         <= x_next;
        y_reg         <= y_next;
        base_reg      <= base_next;
        k_reg         <= k_next;
        l_reg         <= l_next;
        mac_idx_reg   <= 4'({2'b00, k_reg} * 4'd3) + 4'({2'b00, l_reg});
        acc_a_reg     <= acc_a_next;
        acc_b_reg     <= acc_b_next;
        last_pend_reg <= last_pend_next;
        value_reg     <= value_next;
        last_reg      <= last_next;
        status_reg    <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            load_count_reg  <= '0;
            fetch_count_reg <= '0;
            energy_min_reg  <= '1;
            energy_max_reg  <= '0;
            image_ready_reg <= 1'b0;
            mac_valid_reg   <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            load_count_reg  <= load_count_next;
            fetch_count_reg <= fetch_count_next;
            energy_min_reg  <= energy_min_next;
            energy_max_reg  <= energy_max_next;
            image_ready_reg <= image_ready_next;
            mac_valid_reg   <= (state_reg == ST_TAP);
            done_reg        <= done_next;
        end
    end

    assign done   = done_reg;
    assign value  = value_reg;
    assign last   = last_reg;
    assign status = status_reg;

    `TKGE_ASSERT_IMPL(a_write_after_drain, state_reg == ST_WRITE, !mac_valid_reg, "tap pipe busy at energy write")
    `TKGE_ASSERT_IMPL(a_not_ready_zero, done_reg && status_reg == STATUS_NOT_READY, value_reg == '0 && !last_reg, "not-ready result carries data")
    `TKGE_ASSERT_IMPL(a_ready_full, image_ready_reg, load_count_reg == total_reg, "ready without full image")
    `TKGE_ASSERT_NEXT(a_div_in_wait, div_start, state_reg == ST_FDIV, "divider started outside fetch")

endmodule
